// ===== design/ymr_pkg.sv =====
// Package for the YMODEM packet receiver: framing symbols, phase and verdict
// codes, and the result record shared by the control logic and the top level.
// No dependencies.
package ymr_pkg;

  // Framing symbols of the serial protocol.
  localparam logic [7:0] SymSoh = 8'h01;
  localparam logic [7:0] SymStx = 8'h02;
  localparam logic [7:0] SymEot = 8'h04;
  localparam logic [7:0] SymCa  = 8'h18;

  // Receiver phases.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhIdle = 3'd0;
  localparam logic [PhaseW-1:0] PhCa2  = 3'd1;
  localparam logic [PhaseW-1:0] PhBlk  = 3'd2;
  localparam logic [PhaseW-1:0] PhCmp  = 3'd3;
  localparam logic [PhaseW-1:0] PhData = 3'd4;
  localparam logic [PhaseW-1:0] PhCrcH = 3'd5;
  localparam logic [PhaseW-1:0] PhCrcL = 3'd6;

  // Packet verdict codes.
  localparam logic [2:0] VAck     = 3'd0;
  localparam logic [2:0] VNak     = 3'd1;
  localparam logic [2:0] VAckC    = 3'd2;
  localparam logic [2:0] VPoll    = 3'd3;
  localparam logic [2:0] VEnd     = 3'd4;
  localparam logic [2:0] VCancel  = 3'd5;
  localparam logic [2:0] VSession = 3'd6;

  // Result kinds.
  localparam logic KindData    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // Payload sizes and the byte counter width.
  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] ShortSize = 11'd128;
  localparam logic [CountW-1:0] LongSize  = 11'd1024;

  // CRC16-XMODEM polynomial.
  localparam logic [15:0] CrcPoly = 16'h1021;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] flash_address;
    logic        is_header;
    logic [2:0]  verdict;
  } res_t;

endpackage

// ===== design/ymr_if.sv =====
// Channel interfaces of the YMODEM packet receiver: received items in and
// result items out, each with a valid/ready handshake. No dependencies.
interface ymr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink (input valid, input command, input rx_byte, output ready);
endinterface

interface ymr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [31:0] flash_address;
  logic        is_header;
  logic [2:0]  verdict;

  modport source (output valid, output kind, output data_byte, output flash_address,
                  output is_header, output verdict, input ready);
  modport sink (input valid, input kind, input data_byte, input flash_address,
                input is_header, input verdict, output ready);
endinterface

// ===== design/ymr_crc.sv =====
// One-byte update of CRC16-XMODEM (polynomial 0x1021, MSB first).
// Depends on ymr_pkg for the polynomial.
module ymr_crc
  import ymr_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {byte_i, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_o = c;
  end

endmodule

// ===== design/ymr_fsm.sv =====
// Packet framing, sequence checks and verdict logic of the YMODEM receiver.
// Depends on ymr_pkg and instantiates ymr_crc.
module ymr_fsm
  import ymr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [31:0] flash_base_i,
  output logic        res_valid_o,
  output res_t        res_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic              long_q, long_d;
  logic [CountW-1:0] count_q, count_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        blk_q, blk_d;
  logic [7:0]        crc_hi_q, crc_hi_d;
  logic [7:0]        exp_seq_q, exp_seq_d;
  logic [31:0]       offset_q, offset_d;
  logic              in_file_q, in_file_d;
  logic              pair_bad_q, pair_bad_d;
  logic              head_empty_q, head_empty_d;

  logic [15:0]       crc_next;
  logic [CountW-1:0] size;
  logic [CountW-1:0] count_inc;
  logic [15:0]       crc_got;

  ymr_crc u_crc (
    .crc_i  (crc_q),
    .byte_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign size      = long_q ? LongSize : ShortSize;
  assign count_inc = count_q + CountW'(1);
  assign crc_got   = {crc_hi_q, rx_byte_i};

  always_comb begin
    phase_d      = phase_q;
    long_d       = long_q;
    count_d      = count_q;
    crc_d        = crc_q;
    blk_d        = blk_q;
    crc_hi_d     = crc_hi_q;
    exp_seq_d    = exp_seq_q;
    offset_d     = offset_q;
    in_file_d    = in_file_q;
    pair_bad_d   = pair_bad_q;
    head_empty_d = head_empty_q;
    res_valid_o  = 1'b0;
    res_o        = '0;
    res_o.kind   = KindVerdict;
    res_o.verdict = VPoll;

    if (command_i) begin
      // A timeout drops whatever packet was in progress.
      res_valid_o = 1'b1;
      phase_d     = PhIdle;
    end else begin
      case (phase_q)
        PhIdle: begin
          if (rx_byte_i == SymSoh || rx_byte_i == SymStx) begin
            long_d  = (rx_byte_i == SymStx);
            count_d = '0;
            crc_d   = '0;
            phase_d = PhBlk;
          end else if (rx_byte_i == SymEot) begin
            in_file_d     = 1'b0;
            exp_seq_d     = '0;
            offset_d      = '0;
            res_valid_o   = 1'b1;
            res_o.verdict = VEnd;
          end else if (rx_byte_i == SymCa) begin
            phase_d = PhCa2;
          end else begin
            res_valid_o = 1'b1;
          end
        end
        PhCa2: begin
          res_valid_o = 1'b1;
          phase_d     = PhIdle;
          if (rx_byte_i == SymCa) begin
            in_file_d     = 1'b0;
            exp_seq_d     = '0;
            offset_d      = '0;
            res_o.verdict = VCancel;
          end
        end
        PhBlk: begin
          blk_d   = rx_byte_i;
          phase_d = PhCmp;
        end
        PhCmp: begin
          pair_bad_d = (blk_q != ~rx_byte_i);
          phase_d    = PhData;
        end
        PhData: begin
          if (count_q == '0) begin
            head_empty_d = (rx_byte_i == 8'h00);
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KindData;
          res_o.data_byte = rx_byte_i;
          res_o.verdict   = VAck;
          res_o.is_header = ~in_file_q;
          res_o.flash_address = in_file_q ?
              (flash_base_i + offset_q + 32'(count_q)) : 32'h0;
          crc_d   = crc_next;
          count_d = count_inc;
          if (count_inc >= size) begin
            phase_d = PhCrcH;
          end
        end
        PhCrcH: begin
          crc_hi_d = rx_byte_i;
          phase_d  = PhCrcL;
        end
        PhCrcL: begin
          res_valid_o = 1'b1;
          phase_d     = PhIdle;
          if (pair_bad_q) begin
            res_o.verdict = VPoll;
          end else if (!in_file_q) begin
            if (blk_q != 8'h00 || crc_got != crc_q) begin
              res_o.verdict = VNak;
            end else if (head_empty_q) begin
              res_o.verdict = VSession;
            end else begin
              res_o.verdict = VAckC;
              in_file_d     = 1'b1;
              exp_seq_d     = 8'd1;
              offset_d      = '0;
            end
          end else if (blk_q != exp_seq_q || crc_got != crc_q) begin
            res_o.verdict = VNak;
          end else begin
            res_o.verdict = VAck;
            exp_seq_d     = exp_seq_q + 8'd1;
            offset_d      = offset_q + 32'(size);
          end
        end
        default: begin
          res_valid_o = 1'b0;
          phase_d     = PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      long_q       <= 1'b0;
      count_q      <= '0;
      crc_q        <= '0;
      blk_q        <= '0;
      crc_hi_q     <= '0;
      exp_seq_q    <= '0;
      offset_q     <= '0;
      in_file_q    <= 1'b0;
      pair_bad_q   <= 1'b0;
      head_empty_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      long_q       <= long_d;
      count_q      <= count_d;
      crc_q        <= crc_d;
      blk_q        <= blk_d;
      crc_hi_q     <= crc_hi_d;
      exp_seq_q    <= exp_seq_d;
      offset_q     <= offset_d;
      in_file_q    <= in_file_d;
      pair_bad_q   <= pair_bad_d;
      head_empty_q <= head_empty_d;
    end
  end

endmodule

// ===== design/ymodem_packet_receiver.sv =====
// YMODEM packet receiver: an accepted request passes the input register, then the
// result register; throughput is one request per cycle while the result side is
// not stalled, with a single byte-wide CRC and framing step between them.
// A request that gives no result leaves the result register free.
// rst_ni clears the phase, sequence, offset and flags and sets flash_base to 0.
module ymodem_packet_receiver
  import ymr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        flash_base_we_i,
  input  logic [31:0] flash_base_i,
  ymr_in_if.sink      in_i,
  ymr_out_if.source   out_o
);

  // Configuration register. The user must write it only while no request is in flight; the block does not enforce this.
  logic [31:0] flash_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flash_base_q <= '0;
    end else if (flash_base_we_i) begin
      flash_base_q <= flash_base_i;
    end
  end

  // Input register. A held request moves on once the result register can take
  // whatever it produces, which is the case when that register is empty or is
  // being drained in the same cycle.
  logic       in_valid_q;
  logic       in_cmd_q;
  logic [7:0] in_byte_q;
  logic       out_free;
  logic       step;

  assign out_free   = ~out_o.valid | out_o.ready;
  assign step       = in_valid_q & out_free;
  assign in_i.ready = ~in_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_cmd_q  <= in_i.command;
      in_byte_q <= in_i.rx_byte;
    end
  end

  // Framing, CRC and verdict logic. Its state advances only on a step.
  logic res_valid;
  res_t res;

  ymr_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .command_i    (in_cmd_q),
    .rx_byte_i    (in_byte_q),
    .flash_base_i (flash_base_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register.
  logic out_valid_q;
  res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step & res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_q.kind;
  assign out_o.data_byte     = out_q.data_byte;
  assign out_o.flash_address = out_q.flash_address;
  assign out_o.is_header     = out_q.is_header;
  assign out_o.verdict       = out_q.verdict;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the YMODEM packet receiver: directed framing cases,
// then randomized sessions of well-formed and damaged packets under random stalls.
// Depends on ymr_pkg, the channel interfaces and ymodem_packet_receiver.
module testbench
  import ymr_pkg::*;
;

  // Codes of the command field of a request.
  localparam bit CmdByte = 1'b0;
  localparam bit CmdTick = 1'b1;

  // Tracks the receiver's protocol state and keeps the results it still owes.
  // Every accepted request is fed to note_request, and every accepted result
  // is compared against the oldest outstanding expectation by check_result.
  class ymodem_tracker;
    logic [31:0]       flash_base = '0;
    logic [PhaseW-1:0] phase      = PhIdle;
    bit                long_pkt   = 1'b0;
    bit                in_file    = 1'b0;
    bit                pair_bad   = 1'b0;
    bit                head_empty = 1'b0;
    logic [CountW-1:0] count      = '0;
    logic [15:0]       crc_acc    = '0;
    logic [7:0]        blk_no     = '0;
    logic [7:0]        crc_hi     = '0;
    logic [7:0]        exp_seq    = '0;
    logic [31:0]       offset     = '0;
    res_t              pending_q[$];
    int                mismatches = 0;
    int                results    = 0;
    int                verdict_hits[8];
    int                shown      = 0;

    function int pending();
      return pending_q.size();
    endfunction

    // One byte of CRC16-XMODEM, most significant bit first.
    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
        x = x[15] ? ((x << 1) ^ CrcPoly) : (x << 1);
      end
      return x;
    endfunction

    function res_t close_packet(logic [2:0] v);
      res_t r;
      r = '0;
      r.kind = KindVerdict;
      r.verdict = v;
      phase = PhIdle;
      return r;
    endfunction

    function void drop_file();
      in_file = 1'b0;
      exp_seq = '0;
      offset = '0;
    endfunction

    function void note_request(bit cmd, logic [7:0] b);
      res_t              r;
      bit                made;
      logic [CountW-1:0] size;
      logic [15:0]       got;
      r = '0;
      made = 1'b1;
      size = long_pkt ? LongSize : ShortSize;
      if (cmd == CmdTick) begin
        r = close_packet(VPoll);
      end else begin
        case (phase)
          PhIdle: begin
            if (b == SymSoh || b == SymStx) begin
              long_pkt = (b == SymStx);
              count = '0;
              crc_acc = '0;
              phase = PhBlk;
              made = 1'b0;
            end else if (b == SymEot) begin
              drop_file();
              r = close_packet(VEnd);
            end else if (b == SymCa) begin
              phase = PhCa2;
              made = 1'b0;
            end else begin
              r = close_packet(VPoll);
            end
          end
          PhCa2: begin
            if (b == SymCa) begin
              drop_file();
              r = close_packet(VCancel);
            end else begin
              r = close_packet(VPoll);
            end
          end
          PhBlk: begin
            blk_no = b;
            phase = PhCmp;
            made = 1'b0;
          end
          PhCmp: begin
            pair_bad = (blk_no != ~b);
            phase = PhData;
            made = 1'b0;
          end
          PhData: begin
            if (count == '0) head_empty = (b == 8'h00);
            r.kind = KindData;
            r.data_byte = b;
            r.flash_address = in_file ? flash_base + offset + 32'(count) : '0;
            r.is_header = !in_file;
            crc_acc = crc_next(crc_acc, b);
            count = count + 1'b1;
            if (count >= size) phase = PhCrcH;
          end
          PhCrcH: begin
            crc_hi = b;
            phase = PhCrcL;
            made = 1'b0;
          end
          PhCrcL: begin
            got = {crc_hi, b};
            if (pair_bad) begin
              r = close_packet(VPoll);
            end else if (!in_file) begin
              if (blk_no != 8'h00 || got != crc_acc) begin
                r = close_packet(VNak);
              end else if (head_empty) begin
                r = close_packet(VSession);
              end else begin
                in_file = 1'b1;
                exp_seq = 8'h01;
                offset = '0;
                r = close_packet(VAckC);
              end
            end else if (blk_no != exp_seq || got != crc_acc) begin
              r = close_packet(VNak);
            end else begin
              exp_seq = exp_seq + 1'b1;
              offset = offset + 32'(size);
              r = close_packet(VAck);
            end
          end
          default: begin
            phase = PhIdle;
            made = 1'b0;
          end
        endcase
      end
      if (made) pending_q.push_back(r);
    endfunction

    function void mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (shown < 60) begin
        shown++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (shown < 60) begin
          shown++;
          $display("%0t: result with none expected, got kind %0d byte %h verdict %0d",
                   $time, got.kind, got.data_byte, got.verdict);
        end
        return;
      end
      want = pending_q.pop_front();
      if (want.kind == KindVerdict) verdict_hits[want.verdict]++;
      if (got.kind !== want.kind) mismatch("kind", want.kind, got.kind);
      if (got.data_byte !== want.data_byte) mismatch("data_byte", want.data_byte, got.data_byte);
      if (got.flash_address !== want.flash_address) begin
        mismatch("flash_address", want.flash_address, got.flash_address);
      end
      if (got.is_header !== want.is_header) mismatch("is_header", want.is_header, got.is_header);
      if (got.verdict !== want.verdict) mismatch("verdict", want.verdict, got.verdict);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        flash_base_we;
  logic [31:0] flash_base_d;

  ymr_in_if  in_ch ();
  ymr_out_if out_ch ();

  ymodem_packet_receiver dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .flash_base_we_i (flash_base_we),
    .flash_base_i    (flash_base_d),
    .in_i            (in_ch),
    .out_o           (out_ch)
  );

  ymodem_tracker board;

  // Run statistics and stimulus bookkeeping.
  int sent       = 0;
  int bases_used = 0;
  int longs_sent = 0;
  bit long_done  = 1'b0;
  int phase_no;

  // When set, neither side inserts idle cycles, so the block also sees
  // stretches of back-to-back traffic.
  bit no_idle = 1'b0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Gap lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Alternate between idling and no-idle stretches. The flag changes on the
  // falling edge so that it never races with the processes that read it.
  initial begin
    forever begin
      repeat ($urandom_range(300, 800)) @(negedge clk);
      no_idle = 1'b1;
      repeat ($urandom_range(40, 150)) @(negedge clk);
      no_idle = 1'b0;
    end
  end

  // Offer one request and wait until it is taken. The handshake is sampled on
  // the falling edge, where ready is stable, and takes effect at the next
  // rising edge; the task returns in the time step of that edge.
  task automatic send_request(input bit cmd, input logic [7:0] b);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.rx_byte <= b;
    do begin
      @(negedge clk);
      took = (in_ch.ready === 1'b1);
      @(posedge clk);
    end while (!took);
    board.note_request(cmd, b);
    sent++;
  endtask

  // Send a whole packet. Positions: 0 start symbol, 1 block number, 2 its
  // complement, then the payload, then the CRC high and low bytes. When cut_at
  // names a position, a timeout tick goes there instead and the packet stops.
  // The correct CRC is read from the tracker, which has just folded in the
  // payload; callers make sure the receiver is waiting for a start byte.
  task automatic send_packet(input bit long_p, input logic [7:0] blk, input logic [7:0] cmp,
                             input bit empty_head, input bit bad_crc, input int cut_at);
    int          size;
    int          pos;
    logic [15:0] crc_word;
    logic [7:0]  b;
    size = long_p ? 1024 : 128;
    crc_word = '0;
    for (pos = 0; pos < size + 5; pos++) begin
      if (pos == cut_at) begin
        send_request(CmdTick, 8'($urandom_range(0, 255)));
        return;
      end
      if (pos == 0) begin
        b = long_p ? SymStx : SymSoh;
      end else if (pos == 1) begin
        b = blk;
      end else if (pos == 2) begin
        b = cmp;
      end else if (pos == 3) begin
        b = empty_head ? 8'h00 : 8'($urandom_range(1, 255));
      end else if (pos < size + 3) begin
        b = 8'($urandom_range(0, 255));
      end else if (pos == size + 3) begin
        crc_word = board.crc_acc;
        if (bad_crc) crc_word = crc_word ^ (16'h0001 << $urandom_range(0, 15));
        b = crc_word[15:8];
      end else begin
        b = crc_word[7:0];
      end
      send_request(CmdByte, b);
    end
  endtask

  // The next packet of a session: a header when no file is open, otherwise the
  // data block the receiver expects. About a quarter of them are damaged: bad
  // CRC, bad complement, wrong block number, cut by a timeout, or an empty
  // header. The first data packet sent with a file open is a long one, unless a long packet has gone out before.
  task automatic send_flow_packet();
    bit         long_p;
    bit         empty_head;
    bit         bad_crc;
    logic [7:0] blk;
    logic [7:0] cmp;
    int         fault;
    int         cut_at;
    int         size;
    if (board.phase != PhIdle) send_request(CmdTick, 8'($urandom_range(0, 255)));
    long_p = (board.in_file && !long_done) || ($urandom_range(0, 79) == 0);
    if (long_p) begin
      long_done = 1'b1;
      longs_sent++;
    end
    size = long_p ? 1024 : 128;
    blk = board.in_file ? board.exp_seq : 8'h00;
    cmp = ~blk;
    empty_head = 1'b0;
    bad_crc = 1'b0;
    cut_at = -1;
    fault = $urandom_range(0, 99);
    if (fault < 8) begin
      bad_crc = 1'b1;
    end else if (fault < 13) begin
      cmp = ~blk ^ 8'($urandom_range(1, 255));
    end else if (fault < 18) begin
      blk = blk + 8'($urandom_range(1, 255));
      cmp = ~blk;
    end else if (fault < 23) begin
      cut_at = $urandom_range(0, size + 4);
    end else if (fault < 27 && !board.in_file) begin
      empty_head = 1'b1;
    end
    send_packet(long_p, blk, cmp, empty_head, bad_crc, cut_at);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_request(($urandom_range(0, 5) == 0) ? CmdTick : CmdByte,
                   8'($urandom_range(0, 255)));
    end
  endtask

  // Random traffic until quota more requests have gone out. Most of it is
  // session packets; the rest is end of file, cancels, broken cancels,
  // timeouts and garbage.
  task automatic run_random_phase(input int quota);
    int stop_at;
    int pick;
    stop_at = sent + quota;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        send_flow_packet();
      end else if (pick < 86) begin
        send_request(CmdByte, SymEot);
      end else if (pick < 88) begin
        send_request(CmdByte, SymCa);
        send_request(CmdByte, SymCa);
      end else if (pick < 90) begin
        send_request(CmdByte, SymCa);
        send_request(CmdByte, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_request(CmdTick, 8'($urandom_range(0, 255)));
      end else begin
        send_noise($urandom_range(1, 8));
      end
    end
  endtask

  // Hold the sender off until every outstanding result has been taken, then
  // let the pipeline empty of requests that give no result.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The base register is only written while nothing is in flight.
  task automatic set_flash_base(input logic [31:0] v);
    flash_base_we <= 1'b1;
    flash_base_d  <= v;
    @(posedge clk);
    flash_base_we <= 1'b0;
    board.flash_base = v;
    bases_used++;
  endtask

  // Result side: ready is low through reset, then toggles with random stall
  // lengths.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      hold = pick_gap();
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // A result handshake seen on the falling edge completes at the next rising
  // edge, and the values are stable in between.
  always @(negedge clk) begin
    res_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.kind          = out_ch.kind;
      got.data_byte     = out_ch.data_byte;
      got.flash_address = out_ch.flash_address;
      got.is_header     = out_ch.is_header;
      got.verdict       = out_ch.verdict;
      board.check_result(got);
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #2000000;
    $display("ymodem_packet_receiver test failed");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.command = CmdByte;
    in_ch.rx_byte = '0;
    flash_base_we = 1'b0;
    flash_base_d  = '0;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_flash_base(32'h0000_0000);

    // Directed framing cases. A timeout tick ignores its byte, even a start
    // symbol, and gives a poll.
    send_request(CmdTick, SymSoh);
    // Unknown start bytes at both extremes.
    send_request(CmdByte, 8'h00);
    send_request(CmdByte, 8'hff);
    // End of file.
    send_request(CmdByte, SymEot);
    // Cancel, then a lone CA followed by a start symbol, which is not framed.
    send_request(CmdByte, SymCa);
    send_request(CmdByte, SymCa);
    send_request(CmdByte, SymCa);
    send_request(CmdByte, SymSoh);
    // A lone CA cut by a timeout.
    send_request(CmdByte, SymCa);
    send_request(CmdTick, 8'h00);
    // Packets dropped by a timeout right after the start and after the block.
    send_request(CmdByte, SymSoh);
    send_request(CmdTick, 8'h00);
    send_request(CmdByte, SymStx);
    send_request(CmdByte, 8'h01);
    send_request(CmdTick, SymCa);
    // One header payload byte, then a timeout in the middle of the payload.
    send_request(CmdByte, SymSoh);
    send_request(CmdByte, 8'h00);
    send_request(CmdByte, 8'hff);
    send_request(CmdByte, 8'hff);
    send_request(CmdTick, 8'hff);
    wait_for_results();

    // Opening session with random payloads: an empty header ends the session,
    // a header with a nonzero block is refused, then a real file whose first
    // block is repeated once.
    set_flash_base(32'($urandom()));
    send_request(CmdByte, SymEot);
    send_packet(1'b0, 8'h00, 8'hff, 1'b1, 1'b0, -1);
    send_packet(1'b0, 8'h05, 8'hfa, 1'b0, 1'b0, -1);
    send_packet(1'b0, 8'h00, 8'hff, 1'b0, 1'b0, -1);
    send_packet(1'b0, 8'h01, 8'hfe, 1'b0, 1'b0, -1);
    send_packet(1'b0, 8'h01, 8'hfe, 1'b0, 1'b0, -1);
    send_packet(1'b0, 8'h02, 8'hfd, 1'b0, 1'b0, -1);
    wait_for_results();

    // Random phases, each under its own base address. The extremes make the
    // flash address wrap inside a packet.
    for (phase_no = 0; sent < 1800; phase_no++) begin
      case (phase_no % 5)
        0: set_flash_base(32'hffff_ffff);
        1: set_flash_base(32'hffff_ff80);
        3: set_flash_base(32'h0000_0000);
        default: set_flash_base(32'($urandom()));
      endcase
      run_random_phase(300);
      wait_for_results();
    end
    repeat (8) @(posedge clk);

    $display("Covered %0d requests and %0d results under %0d base settings, %0d long packets.",
             sent, board.results, bases_used, longs_sent);
    $display("Verdicts: ack %0d, nak %0d, ack+C %0d, poll %0d, end %0d, cancel %0d, session %0d.",
             board.verdict_hits[VAck], board.verdict_hits[VNak], board.verdict_hits[VAckC],
             board.verdict_hits[VPoll], board.verdict_hits[VEnd], board.verdict_hits[VCancel],
             board.verdict_hits[VSession]);
    if (board.mismatches == 0) begin
      $display("ymodem_packet_receiver test passed");
    end else begin
      $display("ymodem_packet_receiver test failed");
    end
    $finish;
  end

endmodule
